[src/clock_tick_with_minute_events_core_defines.svh]
// Assertion macros shared by the clock tick checker.
`ifndef CLOCK_TICK_WITH_MINUTE_EVENTS_CORE_DEFINES_SVH
`define CLOCK_TICK_WITH_MINUTE_EVENTS_CORE_DEFINES_SVH

// Same-cycle implication, checked at every edge outside reset.
`define CLKT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("clkt: same-cycle check failed");

// Next-cycle implication, checked at every edge outside reset.
`define CLKT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("clkt: next-cycle check failed");

`endif

[src/clkt_pkg.sv]
// Types, constants and event codes for the twelve-hour clock tick block.
`default_nettype none
package clkt_pkg;

    localparam int unsigned ADD_W   = 3;
    localparam int unsigned SEC_W   = 7;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned HOUR_W  = 4;
    localparam int unsigned WDAY_W  = 3;
    localparam int unsigned DOY_W   = 9;
    localparam int unsigned YEAR_W  = 16;
    localparam int unsigned CODE_W  = 3;
    localparam int unsigned CFG_IDX_W = 4;

    localparam logic [SEC_W-1:0]  SEC_PER_MIN    = SEC_W'(60);
    localparam logic [MIN_W-1:0]  MIN_PER_HOUR   = MIN_W'(60);
    localparam logic [MIN_W-1:0]  HALF_HOUR      = MIN_W'(30);
    localparam logic [MIN_W-1:0]  MIN_TWENTY     = MIN_W'(20);
    localparam logic [MIN_W-1:0]  MIN_FIFTY      = MIN_W'(50);
    localparam logic [HOUR_W-1:0] HOURS_HALF_DAY = HOUR_W'(12);
    localparam logic [HOUR_W-1:0] HOUR_FIRST     = HOUR_W'(1);
    localparam logic [WDAY_W-1:0] DAYS_PER_WEEK  = WDAY_W'(7);
    localparam logic [DOY_W:0]    YEAR_LIMIT     = (DOY_W+1)'(366);
    localparam logic [DOY_W-1:0]  DOY_FIRST      = DOY_W'(1);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_BASE      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_BASE_HALF = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_HALF_BASE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_HOUR_BASE = CFG_IDX_W'(3);

    typedef enum logic [CODE_W-1:0] {
        EV_NONE      = 3'd0,
        EV_MINUTE    = 3'd1,
        EV_HALF_HOUR = 3'd2,
        EV_TRIG_LOW  = 3'd3,
        EV_TWENTY    = 3'd4,
        EV_TRIG_BASE = 3'd5
    } t_event;

    typedef struct packed {
        logic [MIN_W-1:0] base;
        logic [MIN_W-1:0] base_plus_half;
        logic [MIN_W-1:0] half_minus_base;
        logic [MIN_W-1:0] hour_minus_base;
    } t_trig_cfg;

    typedef struct packed {
        logic [SEC_W-1:0]  seconds;
        logic [MIN_W-1:0]  minute;
        logic [HOUR_W-1:0] hour;
        logic              pm;
        logic [WDAY_W-1:0] weekday;
        logic [DOY_W-1:0]  day_of_year;
        logic [YEAR_W-1:0] year;
        logic              leap;
    } t_clk_state;

    typedef struct packed {
        t_event            event_code;
        logic [MIN_W-1:0]  minute;
        logic [HOUR_W-1:0] hour;
        logic              pm;
        logic [WDAY_W-1:0] weekday;
        logic [DOY_W-1:0]  day_of_year;
        logic [YEAR_W-1:0] year;
        logic              leap;
        logic              date_advanced;
    } t_tick_result;

endpackage
`default_nettype wire

[src/clock_tick_with_minute_events_core.sv]
// Top level of the twelve-hour clock tick block with minute event codes.
//
//   channel  direction  handshake                  payload
//   in       sink       i_in_valid / o_in_stall    i_add_seconds
//   out      source     o_out_valid / i_out_stall  o_event_code .. o_date_advanced
//   cfg      sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Each beat lands in the input register; from there the tick logic runs, updates
// the clock state and loads the result register once that register is free.
// Throughput is one beat per cycle without out stalls; the input register keeps
// taking beats while the result register is full as long as the result moves on.
// Stall on the out side holds the result and backs up into the input register.
// Reset (synchronous, active low) clears valids, triggers and the clock
// state: 12:00:00 AM, weekday 0, day 1, year 0, leap set.
`default_nettype none
module clock_tick_with_minute_events_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input beats
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [clkt_pkg::ADD_W-1:0]      i_add_seconds,
    // result beats
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [clkt_pkg::CODE_W-1:0]          o_event_code,
    output logic [clkt_pkg::MIN_W-1:0]           o_out_minute,
    output logic [clkt_pkg::HOUR_W-1:0]          o_out_hour,
    output logic                                 o_out_pm,
    output logic [clkt_pkg::WDAY_W-1:0]          o_out_weekday,
    output logic [clkt_pkg::DOY_W-1:0]           o_out_day_of_year,
    output logic [clkt_pkg::YEAR_W-1:0]          o_out_year,
    output logic                                 o_out_leap,
    output logic                                 o_date_advanced,
    // configuration writes
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [clkt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [clkt_pkg::MIN_W-1:0]      i_cfg_data
);

    // input register
    logic                         r_in_valid;
    logic [clkt_pkg::ADD_W-1:0]   r_in_add;
    // clock state
    clkt_pkg::t_clk_state         r_state;
    clkt_pkg::t_clk_state         n_state;
    // result register
    logic                         r_out_valid;
    clkt_pkg::t_tick_result       r_out;
    clkt_pkg::t_tick_result       n_out;

    clkt_pkg::t_trig_cfg          cfg;
    logic                         in_take;
    logic                         advance;
    logic                         out_free;

    // Config writes never wait
    assign o_cfg_ready = 1'b1;

    clkt_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    clkt_step u_step (
        .i_state  (r_state),
        .i_cfg    (cfg),
        .i_add    (r_in_add),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Result register frees up when empty or when its beat is taken now
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid          <= 1'b0;
            r_out_valid         <= 1'b0;
            r_state.seconds     <= '0;
            r_state.minute      <= '0;
            r_state.hour        <= clkt_pkg::HOURS_HALF_DAY;
            r_state.pm          <= 1'b0;
            r_state.weekday     <= '0;
            r_state.day_of_year <= clkt_pkg::DOY_FIRST;
            r_state.year        <= '0;
            r_state.leap        <= 1'b1;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_add <= i_add_seconds;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_event_code      = r_out.event_code;
    assign o_out_minute      = r_out.minute;
    assign o_out_hour        = r_out.hour;
    assign o_out_pm          = r_out.pm;
    assign o_out_weekday     = r_out.weekday;
    assign o_out_day_of_year = r_out.day_of_year;
    assign o_out_year        = r_out.year;
    assign o_out_leap        = r_out.leap;
    assign o_date_advanced   = r_out.date_advanced;

endmodule
`default_nettype wire

[src/clkt_cfg_regs.sv]
// Trigger minute registers written through the configuration port.
`default_nettype none
module clkt_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_wr_en,
    input  wire logic [clkt_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  wire logic [clkt_pkg::MIN_W-1:0]      i_wr_data,
    output clkt_pkg::t_trig_cfg                  o_cfg
);

    clkt_pkg::t_trig_cfg r_cfg;
    clkt_pkg::t_trig_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_wr_index)
                clkt_pkg::REG_TRIG_BASE:      n_cfg.base            = i_wr_data;
                clkt_pkg::REG_TRIG_BASE_HALF: n_cfg.base_plus_half  = i_wr_data;
                clkt_pkg::REG_TRIG_HALF_BASE: n_cfg.half_minus_base = i_wr_data;
                clkt_pkg::REG_TRIG_HOUR_BASE: n_cfg.hour_minus_base = i_wr_data;
                default: ; // unmapped index, dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

[src/clkt_step.sv]
// Next-state and event logic for one tick of the clock.
`default_nettype none
module clkt_step (
    input  wire clkt_pkg::t_clk_state        i_state,
    input  wire clkt_pkg::t_trig_cfg         i_cfg,
    input  wire logic [clkt_pkg::ADD_W-1:0]  i_add,
    output clkt_pkg::t_clk_state             o_state,
    output clkt_pkg::t_tick_result           o_result
);

    logic [clkt_pkg::SEC_W-1:0]  sec_sum;
    logic [clkt_pkg::MIN_W-1:0]  min_inc;
    logic [clkt_pkg::HOUR_W-1:0] hour_inc;
    logic [clkt_pkg::WDAY_W-1:0] wday_inc;
    logic [clkt_pkg::DOY_W:0]    doy_inc;
    logic [clkt_pkg::DOY_W:0]    doy_limit;
    logic [clkt_pkg::YEAR_W-1:0] year_inc;
    clkt_pkg::t_event            min_event;
    clkt_pkg::t_event            code;
    logic                        dated;
    clkt_pkg::t_clk_state        nxt;

    assign sec_sum   = i_state.seconds + clkt_pkg::SEC_W'(i_add);
    assign min_inc   = i_state.minute + clkt_pkg::MIN_W'(1);
    assign hour_inc  = i_state.hour + clkt_pkg::HOUR_W'(1);
    assign wday_inc  = i_state.weekday + clkt_pkg::WDAY_W'(1);
    assign doy_inc   = {1'b0, i_state.day_of_year} + (clkt_pkg::DOY_W+1)'(1);
    assign doy_limit = clkt_pkg::YEAR_LIMIT + (clkt_pkg::DOY_W+1)'(i_state.leap);
    assign year_inc  = i_state.year + clkt_pkg::YEAR_W'(1);

    // Priority: base triggers, then 20/50, then the low triggers
    always_comb begin
        if (min_inc == i_cfg.base || min_inc == i_cfg.base_plus_half) begin
            min_event = clkt_pkg::EV_TRIG_BASE;
        end else if (min_inc == clkt_pkg::MIN_TWENTY || min_inc == clkt_pkg::MIN_FIFTY) begin
            min_event = clkt_pkg::EV_TWENTY;
        end else if (min_inc == i_cfg.half_minus_base ||
                     min_inc == i_cfg.hour_minus_base) begin
            min_event = clkt_pkg::EV_TRIG_LOW;
        end else begin
            min_event = clkt_pkg::EV_MINUTE;
        end
    end

    always_comb begin
        nxt         = i_state;
        code        = clkt_pkg::EV_NONE;
        dated       = 1'b0;
        nxt.seconds = sec_sum;
        if (sec_sum >= clkt_pkg::SEC_PER_MIN) begin
            nxt.seconds = sec_sum - clkt_pkg::SEC_PER_MIN;
            nxt.minute  = min_inc;
            if (min_inc == clkt_pkg::HALF_HOUR) begin
                code = clkt_pkg::EV_HALF_HOUR;
            end else if (min_inc < clkt_pkg::MIN_PER_HOUR) begin
                code = min_event;
            end else begin
                nxt.minute = '0;
                code       = clkt_pkg::EV_HALF_HOUR;
                nxt.hour   = hour_inc;
                if (hour_inc > clkt_pkg::HOURS_HALF_DAY) begin
                    nxt.hour = clkt_pkg::HOUR_FIRST;
                end else if (hour_inc == clkt_pkg::HOURS_HALF_DAY) begin
                    nxt.pm = ~i_state.pm;
                    // PM -> AM edge: new day
                    if (i_state.pm) begin
                        dated       = 1'b1;
                        nxt.weekday = (wday_inc == clkt_pkg::DAYS_PER_WEEK) ? '0 : wday_inc;
                        if (doy_inc >= doy_limit) begin
                            nxt.year        = year_inc;
                            nxt.day_of_year = clkt_pkg::DOY_FIRST;
                            nxt.leap        = (year_inc[1:0] == 2'b00);
                        end else begin
                            nxt.day_of_year = doy_inc[clkt_pkg::DOY_W-1:0];
                        end
                    end
                end
            end
        end
    end

    assign o_state = nxt;

    always_comb begin
        o_result.event_code    = code;
        o_result.minute        = nxt.minute;
        o_result.hour          = nxt.hour;
        o_result.pm            = nxt.pm;
        o_result.weekday       = nxt.weekday;
        o_result.day_of_year   = nxt.day_of_year;
        o_result.year          = nxt.year;
        o_result.leap          = nxt.leap;
        o_result.date_advanced = dated;
    end

endmodule
`default_nettype wire

[src/clkt_checker.sv]
// Port-level checks for the clock tick block, bound to the top level.
`default_nettype none
`include "clock_tick_with_minute_events_core_defines.svh"
module clkt_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire logic [clkt_pkg::CODE_W-1:0]     o_event_code,
    input wire logic [clkt_pkg::MIN_W-1:0]      o_out_minute,
    input wire logic [clkt_pkg::HOUR_W-1:0]     o_out_hour,
    input wire logic                            o_out_pm,
    input wire logic                            o_date_advanced
);

    // held beat keeps its valid, event code, minute and hour
    `CLKT_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_event_code) && $stable(o_out_minute) && $stable(o_out_hour))

    // new day only on the midnight rollover beat
    `CLKT_ASSERT_NOW(a_date_midnight, o_out_valid && o_date_advanced, o_out_hour == clkt_pkg::HOURS_HALF_DAY && !o_out_pm && o_out_minute == '0 && o_event_code == clkt_pkg::EV_HALF_HOUR)

    // hour stays in twelve-hour range
    `CLKT_ASSERT_NOW(a_hour_range, o_out_valid, o_out_hour >= clkt_pkg::HOUR_FIRST && o_out_hour <= clkt_pkg::HOURS_HALF_DAY)

    // an event at minute 0 is the top-of-hour rollover, reported with the half-hour code
    `CLKT_ASSERT_NOW(a_top_of_hour, o_out_valid && o_event_code != clkt_pkg::EV_NONE && o_out_minute == '0, o_event_code == clkt_pkg::EV_HALF_HOUR)

endmodule

bind clock_tick_with_minute_events_core clkt_checker u_clkt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_event_code    (o_event_code),
    .o_out_minute    (o_out_minute),
    .o_out_hour      (o_out_hour),
    .o_out_pm        (o_out_pm),
    .o_date_advanced (o_date_advanced)
);
`default_nettype wire
